FILE: rtl/core/shws_pkg.sv
// ----------------------------------------------------------------------------
// shws_pkg
// Types, byte codes and helpers shared by the shell word splitter files.
// ----------------------------------------------------------------------------
package shws_pkg;

    // Width of the internal completed-word counter.
    localparam int COUNT_WIDTH = 8;
    // Width of the word count shown on the result channel.
    localparam int SHOW_WIDTH  = 8;
    // Width used to compare the counter against the shown limit.
    localparam int CMP_WIDTH   = (COUNT_WIDTH > SHOW_WIDTH) ? COUNT_WIDTH : SHOW_WIDTH;

    // Byte codes that steer the lexer.
    localparam logic [7:0] C_NUL     = 8'h00;
    localparam logic [7:0] C_TAB     = 8'h09;
    localparam logic [7:0] C_NL      = 8'h0A;
    localparam logic [7:0] C_SPACE   = 8'h20;
    localparam logic [7:0] C_DQUOTE  = 8'h22;
    localparam logic [7:0] C_SQUOTE  = 8'h27;
    localparam logic [7:0] C_BSLASH  = 8'h5C;

    // Lexer position within the line.
    typedef enum logic [1:0] {
        LS_START = 2'd0,
        LS_WORD  = 2'd1,
        LS_DQ    = 2'd2,
        LS_SQ    = 2'd3
    } t_lex;

    // Line status codes shown with each result.
    typedef enum logic [1:0] {
        ST_CONT = 2'd0,
        ST_OK   = 2'd1,
        ST_OPEN = 2'd2
    } t_status;

    // Class of a byte once escapes have been resolved.
    typedef enum logic [2:0] {
        CL_END,
        CL_LIT,
        CL_SPACE,
        CL_DQ,
        CL_SQ,
        CL_NONE
    } t_cls;

    // Lexer context carried from one byte to the next.
    typedef struct packed {
        t_lex                   lex;
        logic                   esc;
        logic [COUNT_WIDTH-1:0] count;
    } t_ctx;

    // One result item plus the flag that says whether the byte produced one.
    typedef struct packed {
        logic                  emit;
        logic                  char_valid;
        logic [7:0]            out_char;
        logic                  word_end;
        logic [1:0]            line_status;
        logic [SHOW_WIDTH-1:0] word_count;
    } t_result;

    // Context after reset and after each end of line.
    localparam t_ctx CTX_RESET = '{lex: LS_START, esc: 1'b0, count: '0};

    // Clamp the internal counter to the shown width.
    function automatic logic [SHOW_WIDTH-1:0] sat_show(input logic [COUNT_WIDTH-1:0] cnt);
        logic [CMP_WIDTH-1:0] wide;
        logic [CMP_WIDTH-1:0] limit;
        wide  = CMP_WIDTH'(cnt);
        limit = CMP_WIDTH'({SHOW_WIDTH{1'b1}});
        return (wide > limit) ? {SHOW_WIDTH{1'b1}} : SHOW_WIDTH'(wide);
    endfunction

endpackage

FILE: rtl/core/shws_byte_if.sv
// ----------------------------------------------------------------------------
// shws_byte_if
// Valid/ready channel that carries one byte of the command line.
// ----------------------------------------------------------------------------
interface shws_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

FILE: rtl/core/shws_word_if.sv
// ----------------------------------------------------------------------------
// shws_word_if
// Valid/ready channel that carries one splitter result.
// ----------------------------------------------------------------------------
interface shws_word_if;
    logic                             valid;
    logic                             ready;
    logic                             char_valid;
    logic [7:0]                       out_char;
    logic                             word_end;
    logic [1:0]                       line_status;
    logic [shws_pkg::SHOW_WIDTH-1:0]  word_count;

    modport source (output valid, output char_valid, output out_char, output word_end,
                    output line_status, output word_count, input ready);
    modport sink   (input valid, input char_valid, input out_char, input word_end,
                    input line_status, input word_count, output ready);
endinterface

FILE: rtl/core/shws_lexer.sv
// ----------------------------------------------------------------------------
// shws_lexer
// Single-byte transition of the word splitter: next context and result.
// ----------------------------------------------------------------------------
module shws_lexer (
    input  logic [7:0]        i_byte,
    input  shws_pkg::t_ctx    i_ctx,
    output shws_pkg::t_ctx    o_ctx,
    output shws_pkg::t_result o_res
);

    shws_pkg::t_cls    cls;
    shws_pkg::t_lex    lex_n;
    shws_pkg::t_status status;
    logic              esc_n;
    logic              keep;
    logic              wend;
    logic [shws_pkg::COUNT_WIDTH-1:0] count_n;

    // Resolve escapes and sort the byte into a class.
    always_comb begin
        esc_n = 1'b0;
        if (i_ctx.esc) begin
            cls = (i_byte == shws_pkg::C_NUL) ? shws_pkg::CL_END : shws_pkg::CL_LIT;
        end else begin
            case (i_byte) inside
                shws_pkg::C_BSLASH: begin
                    cls   = shws_pkg::CL_NONE;
                    esc_n = 1'b1;
                end
                shws_pkg::C_NUL:                                     cls = shws_pkg::CL_END;
                shws_pkg::C_SPACE, shws_pkg::C_TAB, shws_pkg::C_NL:  cls = shws_pkg::CL_SPACE;
                shws_pkg::C_DQUOTE:                                  cls = shws_pkg::CL_DQ;
                shws_pkg::C_SQUOTE:                                  cls = shws_pkg::CL_SQ;
                default:                                             cls = shws_pkg::CL_LIT;
            endcase
        end
    end

    // Quote and word tracking.
    always_comb begin
        lex_n  = i_ctx.lex;
        keep   = 1'b0;
        wend   = 1'b0;
        status = shws_pkg::ST_CONT;
        unique case (cls)
            shws_pkg::CL_END: begin
                if (i_ctx.lex == shws_pkg::LS_START) begin
                    status = shws_pkg::ST_OK;
                end else begin
                    wend   = 1'b1;
                    status = (i_ctx.lex == shws_pkg::LS_WORD) ? shws_pkg::ST_OK
                                                               : shws_pkg::ST_OPEN;
                end
            end
            shws_pkg::CL_LIT: begin
                keep = 1'b1;
                if (i_ctx.lex == shws_pkg::LS_START) lex_n = shws_pkg::LS_WORD;
            end
            shws_pkg::CL_SPACE: begin
                if (i_ctx.lex == shws_pkg::LS_WORD) begin
                    wend  = 1'b1;
                    lex_n = shws_pkg::LS_START;
                end else if (i_ctx.lex != shws_pkg::LS_START) begin
                    keep = 1'b1;
                end
            end
            shws_pkg::CL_DQ: begin
                if (i_ctx.lex == shws_pkg::LS_START || i_ctx.lex == shws_pkg::LS_WORD) begin
                    lex_n = shws_pkg::LS_DQ;
                end else if (i_ctx.lex == shws_pkg::LS_DQ) begin
                    lex_n = shws_pkg::LS_WORD;
                end else begin
                    keep = 1'b1;
                end
            end
            shws_pkg::CL_SQ: begin
                if (i_ctx.lex == shws_pkg::LS_START || i_ctx.lex == shws_pkg::LS_WORD) begin
                    lex_n = shws_pkg::LS_SQ;
                end else if (i_ctx.lex == shws_pkg::LS_SQ) begin
                    lex_n = shws_pkg::LS_WORD;
                end else begin
                    keep = 1'b1;
                end
            end
            default: begin
                // A backslash only arms the escape.
            end
        endcase
    end

    // Saturating word counter.
    always_comb begin
        count_n = i_ctx.count;
        if (wend && (i_ctx.count != {shws_pkg::COUNT_WIDTH{1'b1}})) begin
            count_n = i_ctx.count + 1'b1;
        end
    end

    // Result item and next context; an end of line returns to the reset context.
    always_comb begin
        o_res.emit        = keep || wend || (status != shws_pkg::ST_CONT);
        o_res.char_valid  = keep;
        o_res.out_char    = keep ? i_byte : 8'h00;
        o_res.word_end    = wend;
        o_res.line_status = status;
        o_res.word_count  = shws_pkg::sat_show(count_n);
        if (status != shws_pkg::ST_CONT) begin
            o_ctx = shws_pkg::CTX_RESET;
        end else begin
            o_ctx.lex   = lex_n;
            o_ctx.esc   = esc_n;
            o_ctx.count = count_n;
        end
    end

endmodule

FILE: rtl/core/shell_word_splitter.sv
// ----------------------------------------------------------------------------
// shell_word_splitter
// Splits a command line, fed one byte per transaction, into shell words.
// ----------------------------------------------------------------------------
// Usage:
//   i_byte_in carries one byte of the line per transaction; a zero byte ends
//   the line. o_word_out carries a result transaction for every byte that
//   keeps a character, ends a word or ends the line. Separators, quotes and
//   backslashes alone produce no result transaction.
//   A byte passes through the input register and then the result register;
//   the lexer transition is a single combinational step between those
//   registers, so a new byte is accepted every cycle while the result side
//   keeps up.
//   When the receiver stalls, the result register holds its transaction and
//   the input register keeps filling; bytes that produce no result still
//   drain past a stalled result. Input ready drops only once the input
//   register holds a byte that has to wait for the result register.
//   After the end-of-line result the lexer context returns to its reset
//   value. Synchronous reset clears both registers' valid flags and the
//   lexer context; no clearing pass is needed.
// ----------------------------------------------------------------------------
module shell_word_splitter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    shws_byte_if.sink   i_byte_in,
    shws_word_if.source o_word_out
);

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    shws_pkg::t_ctx    r_ctx;
    logic              r_out_valid;
    shws_pkg::t_result r_out;

    shws_pkg::t_ctx    n_ctx;
    shws_pkg::t_result lex_res;
    logic              advance;

    // Lexer transition on the registered byte.
    shws_lexer u_lexer (
        .i_byte (r_in_byte),
        .i_ctx  (r_ctx),
        .o_ctx  (n_ctx),
        .o_res  (lex_res)
    );

    // The registered byte moves on when its result has room or it has none.
    assign advance = r_in_valid &&
                     (!lex_res.emit || !r_out_valid || o_word_out.ready);
    assign i_byte_in.ready = !r_in_valid || advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte_in.ready) begin
            r_in_valid <= i_byte_in.valid;
        end
        if (i_byte_in.ready && i_byte_in.valid) begin
            r_in_byte <= i_byte_in.in_byte;
        end
    end

    // Lexer context.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctx <= shws_pkg::CTX_RESET;
        end else if (advance) begin
            r_ctx <= n_ctx;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && lex_res.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_word_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance && lex_res.emit) begin
            r_out <= lex_res;
        end
    end

    // Result channel drive.
    assign o_word_out.valid       = r_out_valid;
    assign o_word_out.char_valid  = r_out.char_valid;
    assign o_word_out.out_char    = r_out.out_char;
    assign o_word_out.word_end    = r_out.word_end;
    assign o_word_out.line_status = r_out.line_status;
    assign o_word_out.word_count  = r_out.word_count;

endmodule

FILE: rtl/core/shws_checker.sv
// ----------------------------------------------------------------------------
// shws_checker
// Port-level checks on the result channel of the shell word splitter.
// ----------------------------------------------------------------------------
module shws_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_valid,
    input logic                            i_ready,
    input logic                            i_char_valid,
    input logic [7:0]                      i_out_char,
    input logic                            i_word_end,
    input logic [1:0]                      i_line_status,
    input logic [shws_pkg::SHOW_WIDTH-1:0] i_word_count
);

    // A stalled result transaction keeps its payload.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_out_char) && $stable(i_char_valid)
            && $stable(i_word_end) && $stable(i_line_status) && $stable(i_word_count))
        else $error("result payload changed while stalled");

    // A kept character never coincides with a word end or a line end.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_char_valid |->
            !i_word_end && (i_line_status == shws_pkg::ST_CONT))
        else $error("kept character reported together with a word or line end");

    // Only a kept character carries a nonzero character byte.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_char_valid |-> (i_out_char == 8'h00))
        else $error("character byte set without a kept character");

    // A line ending inside an open quote always closes the word in progress.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_line_status == shws_pkg::ST_OPEN) |-> i_word_end)
        else $error("open-quote line end without word end");

    // Every result transaction has something to report.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_char_valid || i_word_end || (i_line_status == shws_pkg::ST_OK)
            || (i_line_status == shws_pkg::ST_OPEN))
        else $error("empty result transaction");

endmodule

bind shell_word_splitter shws_checker u_shws_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (o_word_out.valid),
    .i_ready       (o_word_out.ready),
    .i_char_valid  (o_word_out.char_valid),
    .i_out_char    (o_word_out.out_char),
    .i_word_end    (o_word_out.word_end),
    .i_line_status (o_word_out.line_status),
    .i_word_count  (o_word_out.word_count)
);

FILE: verif/shws_tb_pkg.sv
// ----------------------------------------------------------------------------
// shws_tb_pkg
// Result type and scoreboard for the shell word splitter testbench. The
// scoreboard tracks the lexer context of the line and keeps the results
// still owed by the block.
// ----------------------------------------------------------------------------
package shws_tb_pkg;

    import shws_pkg::*;

    // One result transaction as seen on the output channel.
    typedef struct packed {
        logic                  char_valid;
        logic [7:0]            out_char;
        logic                  word_end;
        t_status               line_status;
        logic [SHOW_WIDTH-1:0] word_count;
    } word_result_t;

    class word_scoreboard;

        t_lex                   lex;
        logic                   esc_seen;
        logic [COUNT_WIDTH-1:0] words_done;
        word_result_t           owed_q[$];
        int                     failures;

        function new();
            failures = 0;
            clear_line();
        endfunction

        // Context at reset and after every end of line.
        function void clear_line();
            lex        = LS_START;
            esc_seen   = 1'b0;
            words_done = '0;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        // Advances the lexer by one accepted input transaction and records
        // the result transaction it should cause, if any.
        function void note_byte(logic [7:0] b);
            t_lex            nxt;
            logic            keep;
            logic            wend;
            logic            escaped;
            t_status         status;
            longint unsigned shown;
            longint unsigned show_top;
            word_result_t    r;

            nxt    = lex;
            keep   = 1'b0;
            wend   = 1'b0;
            status = ST_CONT;

            // An unescaped backslash only arms the escape.
            if (!esc_seen && b == C_BSLASH) begin
                esc_seen = 1'b1;
                return;
            end
            escaped  = esc_seen;
            esc_seen = 1'b0;

            if (b == C_NUL) begin
                // End of line; a dangling backslash is simply dropped.
                if (lex == LS_START) begin
                    status = ST_OK;
                end else begin
                    wend   = 1'b1;
                    status = (lex == LS_WORD) ? ST_OK : ST_OPEN;
                end
            end else if (escaped) begin
                keep = 1'b1;
                if (lex == LS_START) nxt = LS_WORD;
            end else begin
                case (b)
                    C_TAB, C_NL, C_SPACE: begin
                        if (lex == LS_WORD) begin
                            wend = 1'b1;
                            nxt  = LS_START;
                        end else if (lex != LS_START) begin
                            keep = 1'b1;
                        end
                    end
                    C_DQUOTE: begin
                        case (lex)
                            LS_START, LS_WORD: nxt = LS_DQ;
                            LS_DQ:             nxt = LS_WORD;
                            default:           keep = 1'b1;
                        endcase
                    end
                    C_SQUOTE: begin
                        case (lex)
                            LS_START, LS_WORD: nxt = LS_SQ;
                            LS_SQ:             nxt = LS_WORD;
                            default:           keep = 1'b1;
                        endcase
                    end
                    default: begin
                        keep = 1'b1;
                        if (lex == LS_START) nxt = LS_WORD;
                    end
                endcase
            end

            lex = nxt;
            // The counter sticks at its top value.
            if (wend && !(&words_done)) words_done = words_done + 1'b1;

            if (!keep && !wend && status == ST_CONT) return;

            shown    = longint'(words_done);
            show_top = (64'd1 << SHOW_WIDTH) - 64'd1;
            r.char_valid  = keep;
            r.out_char    = keep ? b : 8'h00;
            r.word_end    = wend;
            r.line_status = status;
            r.word_count  = SHOW_WIDTH'((shown > show_top) ? show_top : shown);
            owed_q.push_back(r);

            if (status != ST_CONT) clear_line();
        endfunction

        function void compare_field(string name, longint unsigned want,
                                    longint unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                failures++;
            end
        endfunction

        // Compares one accepted result transaction with the oldest one owed.
        function void check_word(word_result_t got);
            word_result_t want;
            if (owed_q.size() == 0) begin
                $error("result transaction with none expected: char %0d word_end %0d",
                       got.out_char, got.word_end);
                failures++;
                return;
            end
            want = owed_q.pop_front();
            compare_field("char_valid", want.char_valid, got.char_valid);
            compare_field("out_char", want.out_char, got.out_char);
            compare_field("word_end", want.word_end, got.word_end);
            compare_field("line_status", want.line_status, got.line_status);
            compare_field("word_count", want.word_count, got.word_count);
        endfunction

        // Anything still owed at the end of the run is a failure.
        function void close();
            if (owed_q.size() != 0) begin
                $error("%0d result transactions never arrived", owed_q.size());
                failures++;
            end
        endfunction

    endclass

endpackage

FILE: verif/shell_word_splitter_tb.sv
// ----------------------------------------------------------------------------
// shell_word_splitter_tb
// Drives command lines into the shell word splitter and checks every result
// transaction against a scoreboard that tracks the lexer. A short directed
// part covers separators, both quote kinds, escapes and line endings; random
// lines of quoted and escaped words follow, plus noise and one line long
// enough to saturate the word count. Both channels idle at random.
// ----------------------------------------------------------------------------
module shell_word_splitter_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import shws_pkg::*;
    import shws_tb_pkg::*;

    localparam int RANDOM_BYTES = 1550;

    logic i_clk = 1'b0;
    logic i_rst_n;

    shws_byte_if byte_if ();
    shws_word_if word_if ();

    shell_word_splitter uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_byte_in  (byte_if),
        .o_word_out (word_if)
    );

    word_scoreboard board;
    logic [7:0]     line_buf[$];
    bit             steady;
    int             bytes_sent;

    always #4 i_clk = ~i_clk;

    // Watchdog for a hung block.
    initial begin
        #8_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Sender gap in cycles: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(1, 255));
        end while (b inside {C_TAB, C_NL, C_SPACE, C_DQUOTE, C_SQUOTE, C_BSLASH});
        return b;
    endfunction

    function automatic logic [7:0] sep_byte();
        case ($urandom_range(0, 2))
            0:       return C_SPACE;
            1:       return C_TAB;
            default: return C_NL;
        endcase
    endfunction

    function automatic logic [7:0] special_byte();
        case ($urandom_range(0, 5))
            0:       return C_BSLASH;
            1:       return C_DQUOTE;
            2:       return C_SQUOTE;
            3:       return C_SPACE;
            4:       return C_TAB;
            default: return C_NL;
        endcase
    endfunction

    // Backslash followed by any nonzero byte, often one the lexer cares about.
    function automatic void add_escape();
        line_buf.push_back(C_BSLASH);
        if ($urandom_range(0, 2) == 0) line_buf.push_back(special_byte());
        else line_buf.push_back(8'($urandom_range(1, 255)));
    endfunction

    // Quoted run holding separators, the other quote and escapes.
    function automatic void add_quoted(logic [7:0] quote);
        int n;
        n = $urandom_range(0, 4);
        line_buf.push_back(quote);
        repeat (n) begin
            case ($urandom_range(0, 3))
                0: line_buf.push_back(plain_byte());
                1: line_buf.push_back(sep_byte());
                2: line_buf.push_back(quote == C_DQUOTE ? C_SQUOTE : C_DQUOTE);
                default: add_escape();
            endcase
        end
        line_buf.push_back(quote);
    endfunction

    function automatic void add_word();
        int segs;
        segs = $urandom_range(1, 3);
        repeat (segs) begin
            case ($urandom_range(0, 3))
                0: repeat ($urandom_range(1, 4)) line_buf.push_back(plain_byte());
                1: add_escape();
                2: add_quoted(C_DQUOTE);
                default: add_quoted(C_SQUOTE);
            endcase
        end
    endfunction

    // Builds one random line ending in a zero byte: mostly well formed words,
    // sometimes noise that can leave a quote open.
    function automatic void build_line();
        int nwords;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 12)) begin
                case ($urandom_range(0, 2))
                    0: line_buf.push_back(special_byte());
                    1: line_buf.push_back(plain_byte());
                    default: line_buf.push_back(8'($urandom_range(1, 255)));
                endcase
            end
        end else begin
            if ($urandom_range(0, 3) == 0) line_buf.push_back(sep_byte());
            nwords = $urandom_range(0, 6);
            for (int w = 0; w < nwords; w++) begin
                add_word();
                if (w != nwords - 1)
                    repeat ($urandom_range(1, 3)) line_buf.push_back(sep_byte());
            end
            if ($urandom_range(0, 3) == 0) line_buf.push_back(sep_byte());
        end
        if ($urandom_range(0, 11) == 0) line_buf.push_back(C_BSLASH);
        line_buf.push_back(C_NUL);
    endfunction

    // Offers one byte and waits for its transaction; returns at a falling edge.
    task automatic push_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            byte_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        byte_if.valid   <= 1'b1;
        byte_if.in_byte <= b;
        do @(posedge i_clk); while (!byte_if.ready);
        board.note_byte(b);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_line();
        foreach (line_buf[i]) push_byte(line_buf[i]);
        line_buf.delete();
    endtask

    // Holds the sender off until every owed result has been taken.
    task automatic wait_drained();
        byte_if.valid <= 1'b0;
        do @(negedge i_clk); while (board.pending() != 0);
    endtask

    // Result checking at each rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && word_if.valid && word_if.ready)
            board.check_word('{char_valid:  word_if.char_valid,
                               out_char:    word_if.out_char,
                               word_end:    word_if.word_end,
                               line_status: t_status'(word_if.line_status),
                               word_count:  word_if.word_count});
    end

    // Receiver: phases of full rate, random stalls and occasional long stalls.
    initial begin
        int mode;
        int span;
        word_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            mode = $urandom_range(0, 9);
            span = $urandom_range(10, 80);
            if (mode == 9) begin
                repeat ($urandom_range(20, 60)) begin
                    @(negedge i_clk);
                    word_if.ready <= 1'b0;
                end
            end else begin
                repeat (span) begin
                    @(negedge i_clk);
                    word_if.ready <= (mode < 3) ? 1'b1 : ($urandom_range(0, 99) < 70);
                end
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        board           = new();
        bytes_sent      = 0;
        steady          = 1'b0;
        i_rst_n         = 1'b0;
        byte_if.valid   = 1'b0;
        byte_if.in_byte = 8'h00;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Empty line, then separators between words and bytes at the extremes.
        line_buf = '{C_NUL,
                     8'h61, C_SPACE, 8'hFF, C_TAB, 8'h01, C_NL, C_NUL};
        send_line();
        // Empty quoted pairs of both kinds still form words.
        line_buf = '{C_DQUOTE, C_DQUOTE, C_SPACE, C_SQUOTE, C_SQUOTE, C_NUL};
        send_line();
        // Separator, other quote and an escaped quote inside double quotes.
        line_buf = '{C_DQUOTE, C_SPACE, C_SQUOTE, C_BSLASH, C_DQUOTE, C_DQUOTE, C_NUL};
        send_line();
        // Escaped separator opens a word; a trailing backslash is dropped.
        line_buf = '{C_BSLASH, C_SPACE, C_BSLASH, C_NUL};
        send_line();
        // Line ends inside an open quote.
        line_buf = '{C_SQUOTE, C_NUL};
        send_line();
        wait_drained();

        // One line long enough to push the word count to its limit.
        repeat (270) begin
            line_buf.push_back(plain_byte());
            line_buf.push_back(sep_byte());
        end
        line_buf.push_back(C_NUL);
        send_line();

        while (bytes_sent < RANDOM_BYTES) begin
            steady = ($urandom_range(0, 3) == 0);
            build_line();
            send_line();
            if ($urandom_range(0, 7) == 0) wait_drained();
        end

        byte_if.valid <= 1'b0;
        do @(negedge i_clk); while (board.pending() != 0);
        repeat (8) @(posedge i_clk);
        board.close();
        if (board.failures == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
